@@ sv/gradient_noise_2d_unit_defines.svh @@
// assertion macros shared by the checker
`ifndef GRADIENT_NOISE_2D_UNIT_DEFINES_SVH
`define GRADIENT_NOISE_2D_UNIT_DEFINES_SVH

// implication checked on the same edge, ignored while in reset
`define GN_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gradient noise check failed");

// implication checked one edge later, ignored while in reset
`define GN_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gradient noise check failed");

// implication checked one edge later, also across reset
`define GN_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("gradient noise reset check failed");

`endif

@@ sv/gnd_pkg.sv @@
`default_nettype none
package gnd_pkg;
  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

  localparam int CORDIC_STEPS = 17;
  // cordic, gradient and noise datapath widths
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int GW = 18;
  localparam int NW = 38;
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

  typedef logic signed [ZW-1:0] ang_t;
  typedef ang_t atan_tab_t [CORDIC_STEPS];

  // atan(2^-i) in 2^-32 turns
  localparam atan_tab_t ATAN_TURNS = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
    33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772, 33'sd166886,
    33'sd83443, 33'sd41722, 33'sd20861, 33'sd10430
  };

  function automatic logic [31:0] rot16(input logic [31:0] v);
    rot16 = {v[15:0], v[31:16]};
  endfunction
endpackage
`default_nettype wire

@@ sv/gradient_noise_2d_unit.sv @@
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | in_x_coord, in_y_coord (signed q16.16)
// out_    | output    | out_valid/out_stall | out_noise_value (unsigned q0.16)
//
// one transaction accepted per cycle while in_stall is low, one result per transaction
// pipeline: 5 hash stages, 18 cordic stages, 8 dot/blend stages, output
// the whole pipeline moves on a common enable; it freezes only when the output
// register holds a result and out_stall is high
// synchronous active-low reset clears the valid bits only
`default_nettype none
module gradient_noise_2d_unit #(
  parameter int ANGLE_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_x_coord,
  input  wire logic signed [31:0] in_y_coord,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_noise_value
);
  import gnd_pkg::*;

  localparam int CLAT = CORDIC_STEPS + 1;   // cordic lane latency
  localparam int VLEN = 5 + CLAT + 8;       // valid bits before the output register

  // common pipeline enable
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [VLEN-1:0] vld_r;
  logic            out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLEN-2:0], in_valid};
      out_valid_r <= vld_r[VLEN-1];
    end
  end

  // stage 1: split into cell and q0.16 fraction
  logic [31:0] cx0_r, cy0_r;
  logic [15:0] fx1_r, fy1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cx0_r <= 32'(in_x_coord >>> FRAC_BITS);
      cy0_r <= 32'(in_y_coord >>> FRAC_BITS);
      fx1_r <= 16'(unsigned'(in_x_coord[FRAC_BITS-1:0])) << (16 - FRAC_BITS);
      fy1_r <= 16'(unsigned'(in_y_coord[FRAC_BITS-1:0])) << (16 - FRAC_BITS);
    end
  end

  // stage 2: neighbouring cell, wraps at 32 bits
  logic [31:0] cx0b_r, cx1_r, cy0b_r, cy1_r;
  logic [15:0] fx2_r, fy2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cx0b_r <= cx0_r;
      cx1_r  <= cx0_r + 32'd1;
      cy0b_r <= cy0_r;
      cy1_r  <= cy0_r + 32'd1;
      fx2_r  <= fx1_r;
      fy2_r  <= fy1_r;
    end
  end

  // stage 3: first hash multiply, per column
  logic [31:0] a0_r, a1_r, cy0c_r, cy1c_r;
  logic [15:0] fx3_r, fy3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a0_r   <= 32'(cx0b_r * HASH_MUL_A);
      a1_r   <= 32'(cx1_r * HASH_MUL_A);
      cy0c_r <= cy0b_r;
      cy1c_r <= cy1_r;
      fx3_r  <= fx2_r;
      fy3_r  <= fy2_r;
    end
  end

  // stage 4: second multiply, corners ordered 00, 10, 01, 11
  logic [31:0] b_r [4];
  logic [31:0] a0d_r, a1d_r;
  logic [15:0] fx4_r, fy4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      b_r[0] <= 32'((cy0c_r ^ rot16(a0_r)) * HASH_MUL_B);
      b_r[1] <= 32'((cy0c_r ^ rot16(a1_r)) * HASH_MUL_B);
      b_r[2] <= 32'((cy1c_r ^ rot16(a0_r)) * HASH_MUL_B);
      b_r[3] <= 32'((cy1c_r ^ rot16(a1_r)) * HASH_MUL_B);
      a0d_r  <= a0_r;
      a1d_r  <= a1_r;
      fx4_r  <= fx3_r;
      fy4_r  <= fy3_r;
    end
  end

  // stage 5: final hash multiply
  logic [31:0] h_r [4];
  logic [15:0] fx5_r, fy5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      h_r[0] <= 32'((a0d_r ^ rot16(b_r[0])) * HASH_MUL_C);
      h_r[1] <= 32'((a1d_r ^ rot16(b_r[1])) * HASH_MUL_C);
      h_r[2] <= 32'((a0d_r ^ rot16(b_r[2])) * HASH_MUL_C);
      h_r[3] <= 32'((a1d_r ^ rot16(b_r[3])) * HASH_MUL_C);
      fx5_r  <= fx4_r;
      fy5_r  <= fy4_r;
    end
  end

  // four cordic lanes turn each hash into a unit gradient
  logic signed [GW-1:0] gx [4];
  logic signed [GW-1:0] gy [4];
  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_lane
      gnd_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .clk    (clk),
        .en     (en),
        .hash   (h_r[g]),
        .grad_x (gx[g]),
        .grad_y (gy[g])
      );
    end
  endgenerate

  // fraction delay line matching the cordic latency
  logic [15:0] fxd_r [CLAT];
  logic [15:0] fyd_r [CLAT];
  always_ff @(posedge clk) begin
    if (en) begin
      fxd_r[0] <= fx5_r;
      fyd_r[0] <= fy5_r;
      for (int i = 1; i < CLAT; i++) begin
        fxd_r[i] <= fxd_r[i-1];
        fyd_r[i] <= fyd_r[i-1];
      end
    end
  end

  // corner offsets in signed q1.16
  logic signed [GW-1:0] dx0, dx1, dy0, dy1;
  assign dx0 = signed'({2'b00, fxd_r[CLAT-1]});
  assign dy0 = signed'({2'b00, fyd_r[CLAT-1]});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;

  // dot products: multiply, then sum
  logic signed [2*GW-1:0] px_r [4];
  logic signed [2*GW-1:0] py_r [4];
  logic [15:0] fx6_r, fy6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= gx[0] * dx0;  py_r[0] <= gy[0] * dy0;
      px_r[1] <= gx[1] * dx1;  py_r[1] <= gy[1] * dy0;
      px_r[2] <= gx[2] * dx0;  py_r[2] <= gy[2] * dy1;
      px_r[3] <= gx[3] * dx1;  py_r[3] <= gy[3] * dy1;
      fx6_r   <= fxd_r[CLAT-1];
      fy6_r   <= fyd_r[CLAT-1];
    end
  end

  logic signed [NW-1:0] n_r [4];
  logic [15:0] fx7_r, fy7_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        n_r[i] <= NW'(px_r[i]) + NW'(py_r[i]);
      end
      fx7_r <= fx6_r;
      fy7_r <= fy6_r;
    end
  end

  // x blend: difference, multiply, add back
  logic signed [NW:0]   dxa_r, dxb_r;
  logic signed [NW-1:0] n00_r, n01_r, n00m_r, n01m_r;
  logic signed [NW+17:0] mxa_r, mxb_r;
  logic [15:0] fx8_r, fy8_r, fy9_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dxa_r  <= (NW+1)'(n_r[1]) - (NW+1)'(n_r[0]);
      dxb_r  <= (NW+1)'(n_r[3]) - (NW+1)'(n_r[2]);
      n00_r  <= n_r[0];
      n01_r  <= n_r[2];
      fx8_r  <= fx7_r;
      fy8_r  <= fy7_r;
      mxa_r  <= dxa_r * signed'({1'b0, fx8_r});
      mxb_r  <= dxb_r * signed'({1'b0, fx8_r});
      n00m_r <= n00_r;
      n01m_r <= n01_r;
      fy9_r  <= fy8_r;
    end
  end

  logic signed [NW-1:0] ix0_r, ix1_r;
  logic [15:0] fy10_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ix0_r  <= n00m_r + NW'(mxa_r >>> 16);
      ix1_r  <= n01m_r + NW'(mxb_r >>> 16);
      fy10_r <= fy9_r;
    end
  end

  // y blend
  logic signed [NW:0]    dy_r;
  logic signed [NW-1:0]  ix0b_r, ix0c_r, v_r;
  logic signed [NW+17:0] my_r;
  logic [15:0] fy11_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dy_r   <= (NW+1)'(ix1_r) - (NW+1)'(ix0_r);
      ix0b_r <= ix0_r;
      fy11_r <= fy10_r;
      my_r   <= dy_r * signed'({1'b0, fy11_r});
      ix0c_r <= ix0b_r;
      v_r    <= ix0c_r + NW'(my_r >>> 16);
    end
  end

  // map to v/2 + 0.5, round half up, saturate
  logic signed [NW:0]   biased;
  logic signed [NW-17:0] scaled;
  logic [15:0] res_nxt, res_r;
  assign biased = (NW+1)'(v_r) + 39'sd4295032832;
  assign scaled = (NW-16)'(biased >>> 17);
  always_comb begin
    if (scaled < 0) begin
      res_nxt = 16'd0;
    end else if (scaled > 22'sd65535) begin
      res_nxt = 16'hFFFF;
    end else begin
      res_nxt = scaled[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = res_r;
endmodule
`default_nettype wire

@@ sv/gnd_cordic.sv @@
`default_nettype none
module gnd_cordic #(
  parameter int ANGLE_BITS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [31:0]                 hash,
  output logic signed [gnd_pkg::GW-1:0]    grad_x,
  output logic signed [gnd_pkg::GW-1:0]    grad_y
);
  import gnd_pkg::*;

  // keeps only the top angle bits inside the quadrant
  localparam logic [29:0] ZMASK = ~30'((64'd1 << (32 - ANGLE_BITS)) - 64'd1);

  logic signed [CW-1:0] c_r [CORDIC_STEPS];
  logic signed [CW-1:0] s_r [CORDIC_STEPS];
  ang_t                 z_r [CORDIC_STEPS];
  logic [1:0]           q_r [CORDIC_STEPS];

  genvar k;
  generate
    for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [CW-1:0] c_p, s_p, c_nxt, s_nxt;
      ang_t                 z_p, z_nxt;
      logic [1:0]           q_p;
      if (k == 0) begin : g_first
        assign c_p = CORDIC_START;
        assign s_p = '0;
        assign z_p = ang_t'({3'b000, hash[29:0] & ZMASK});
        assign q_p = hash[31:30];
      end else begin : g_rest
        assign c_p = c_r[k-1];
        assign s_p = s_r[k-1];
        assign z_p = z_r[k-1];
        assign q_p = q_r[k-1];
      end
      always_comb begin
        if (!z_p[ZW-1]) begin
          c_nxt = c_p - (s_p >>> k);
          s_nxt = s_p + (c_p >>> k);
          z_nxt = z_p - ATAN_TURNS[k];
        end else begin
          c_nxt = c_p + (s_p >>> k);
          s_nxt = s_p - (c_p >>> k);
          z_nxt = z_p + ATAN_TURNS[k];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          c_r[k] <= c_nxt;
          s_r[k] <= s_nxt;
          z_r[k] <= z_nxt;
          q_r[k] <= q_p;
        end
      end
    end
  endgenerate

  logic signed [CW-1:0] c_rnd, s_rnd;
  logic signed [GW-1:0] c_q, s_q;
  logic signed [GW-1:0] gx_nxt, gy_nxt, gx_r, gy_r;

  // round to q1.16
  assign c_rnd = (c_r[CORDIC_STEPS-1] + 34'sd8192) >>> 14;
  assign s_rnd = (s_r[CORDIC_STEPS-1] + 34'sd8192) >>> 14;
  assign c_q   = c_rnd[GW-1:0];
  assign s_q   = s_rnd[GW-1:0];

  always_comb begin
    case (q_r[CORDIC_STEPS-1])
      2'd0:    begin gx_nxt = c_q;  gy_nxt = s_q;  end
      2'd1:    begin gx_nxt = -s_q; gy_nxt = c_q;  end
      2'd2:    begin gx_nxt = -c_q; gy_nxt = -s_q; end
      default: begin gx_nxt = s_q;  gy_nxt = -c_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
  end

  assign grad_x = gx_r;
  assign grad_y = gy_r;
endmodule
`default_nettype wire

@@ sv/gnd_checker.sv @@
`default_nettype none
`include "gradient_noise_2d_unit_defines.svh"
module gnd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_noise_value
);
  `GN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `GN_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_noise_value))
  `GN_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  `GN_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)
  `GN_ASSERT_NOW(a_in_free, in_valid && !out_stall, !in_stall)
endmodule

bind gradient_noise_2d_unit gnd_checker u_gnd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_noise_value (out_noise_value)
);
`default_nettype wire
